// File: src/bwti_pkg.sv
// ----------------------------------------------------------------------------
// bwti_pkg
// shared types and constants of the inverse block-sorting transform
// ----------------------------------------------------------------------------
package bwti_pkg;

    localparam int BYTE_W     = 8;
    localparam int PROW_W     = 12;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int NUM_SYMS   = 256;
    localparam int SYM_W      = 8;
    localparam int SWEEP_W    = 9;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK    = 2'd0,
        RES_EMPTY = 2'd1,
        RES_ERR   = 2'd2
    } res_t;

    typedef struct packed {
        logic capture;
        logic discard;
        logic col_wr;
        logic cnt_load_rd;
        logic cnt_load_wr;
        logic bl_inc;
        logic sum_start;
        logic sum_step;
        logic fill_col_rd;
        logic fill_slot_rd;
        logic fill_wr;
        logic commit;
        logic row_rd;
        logic walk_step;
        logic out_load;
        res_t out_status;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic last;
        logic ready;
        logic full;
        logic rem_zero;
        logic prow_bad;
        logic sum_done;
        logic fill_last;
    } stat_t;

endpackage

// File: src/bwti_ctrl.sv
// ----------------------------------------------------------------------------
// bwti_ctrl
// sequencer for load, table build, walk and result handoff
// ----------------------------------------------------------------------------
module bwti_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  bwti_pkg::stat_t stat,
    output bwti_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD_INC,
        ST_LAST_CHK,
        ST_SUM,
        ST_FILL_COL,
        ST_FILL_SLOT,
        ST_FILL_WR,
        ST_FIN,
        ST_ROW,
        ST_RESP
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    bwti_pkg::res_t  res_reg;
    bwti_pkg::res_t  res_next;
    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.out_status = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.is_read)
                begin
                    if (stat.ready)
                    begin
                        // a decoded block is dropped, then the load is retried
                        cmd.discard = 1'b1;
                    end
                    else if (stat.full)
                    begin
                        cmd.discard = stat.last;
                        res_next    = bwti_pkg::RES_ERR;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        cmd.col_wr      = 1'b1;
                        cmd.cnt_load_rd = 1'b1;
                        state_next      = ST_LOAD_INC;
                    end
                end
                else if (stat.rem_zero)
                begin
                    res_next   = bwti_pkg::RES_EMPTY;
                    state_next = ST_RESP;
                end
                else
                begin
                    cmd.row_rd = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_LOAD_INC:
            begin
                cmd.cnt_load_wr = 1'b1;
                cmd.bl_inc      = 1'b1;
                state_next      = stat.last ? ST_LAST_CHK : ST_IDLE;
            end
            ST_LAST_CHK:
            begin
                if (stat.prow_bad)
                begin
                    cmd.discard = 1'b1;
                    res_next    = bwti_pkg::RES_ERR;
                    state_next  = ST_RESP;
                end
                else
                begin
                    cmd.sum_start = 1'b1;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_done)
                begin
                    state_next = ST_FILL_COL;
                end
            end
            ST_FILL_COL:
            begin
                cmd.fill_col_rd = 1'b1;
                state_next      = ST_FILL_SLOT;
            end
            ST_FILL_SLOT:
            begin
                cmd.fill_slot_rd = 1'b1;
                state_next       = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = stat.fill_last ? ST_FIN : ST_FILL_SLOT;
            end
            ST_FIN:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ROW:
            begin
                cmd.walk_step = 1'b1;
                res_next      = bwti_pkg::RES_OK;
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                cmd.out_load = out_free;
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            res_reg      <= bwti_pkg::RES_OK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_reg      <= res_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// File: src/bwti_datapath.sv
// ----------------------------------------------------------------------------
// bwti_datapath
// column store, symbol histogram, next-row table and walk registers
// ----------------------------------------------------------------------------
module bwti_datapath
#(
    parameter int BLOCK_SIZE = 4096
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [bwti_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  bwti_pkg::cmd_t                     cmd,
    output bwti_pkg::stat_t                    stat,
    output logic [bwti_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    output logic [bwti_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int RW = $clog2(BLOCK_SIZE);
    localparam int LW = $clog2(BLOCK_SIZE + 1);
    localparam int CW = (LW > bwti_pkg::PROW_W) ? LW : bwti_pkg::PROW_W;

    // captured item
    logic                           op_reg;
    logic [bwti_pkg::BYTE_W-1:0]    byte_reg;
    logic                           last_reg;
    logic [bwti_pkg::PROW_W-1:0]    prow_reg;

    // memories
    logic [bwti_pkg::BYTE_W-1:0]    col_mem [BLOCK_SIZE];
    logic [RW-1:0]                  row_mem [BLOCK_SIZE];
    logic [LW-1:0]                  cnt_mem [bwti_pkg::NUM_SYMS];

    logic [bwti_pkg::BYTE_W-1:0]    col_rd_reg;
    logic [RW-1:0]                  row_rd_reg;
    logic [LW-1:0]                  cnt_rd_reg;

    // block state
    logic [LW-1:0]                  bl_reg, bl_next;
    logic [RW-1:0]                  walk_reg, walk_next;
    logic [LW-1:0]                  rem_reg, rem_next;
    logic                           ready_reg, ready_next;
    logic [bwti_pkg::NUM_SYMS-1:0]  vld_reg, vld_next;
    logic [bwti_pkg::SWEEP_W-1:0]   sweep_reg, sweep_next;
    logic                           pend_reg, pend_next;
    logic [bwti_pkg::SYM_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [LW-1:0]                  sum_reg, sum_next;
    logic [LW-1:0]                  fill_reg, fill_next;
    logic [LW-1:0]                  fill_inc;
    logic                           sweep_rd;

    // output word
    logic [bwti_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                           out_final_reg;
    logic [bwti_pkg::STATUS_W-1:0]  out_status_reg;

    // memory ports
    logic                           col_we, col_re;
    logic [RW-1:0]                  col_wa, col_ra;
    logic                           row_we, row_re;
    logic [RW-1:0]                  row_wa, row_ra;
    logic                           cnt_we, cnt_re;
    logic [bwti_pkg::SYM_W-1:0]     cnt_wa, cnt_ra;
    logic [LW-1:0]                  cnt_wd;

    assign fill_inc = fill_reg + LW'(1);
    assign sweep_rd = cmd.sum_step && !sweep_reg[bwti_pkg::SWEEP_W-1];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata[bwti_pkg::BYTE_W-1:0];
            last_reg <= s_tlast;
            prow_reg <= s_tdata[bwti_pkg::BYTE_W +: bwti_pkg::PROW_W];
        end
    end

    always_comb
    begin
        col_we = cmd.col_wr;
        col_wa = bl_reg[RW-1:0];
        col_re = cmd.fill_col_rd || cmd.fill_wr || cmd.walk_step;
        priority if (cmd.fill_col_rd)
        begin
            col_ra = fill_reg[RW-1:0];
        end
        else if (cmd.fill_wr)
        begin
            col_ra = fill_inc[RW-1:0];
        end
        else
        begin
            col_ra = row_rd_reg;
        end

        row_we = cmd.fill_wr;
        row_wa = cnt_rd_reg[RW-1:0];
        row_re = cmd.row_rd;
        row_ra = walk_reg;

        cnt_re = cmd.cnt_load_rd || sweep_rd || cmd.fill_slot_rd;
        priority if (cmd.cnt_load_rd)
        begin
            cnt_ra = byte_reg;
        end
        else if (cmd.fill_slot_rd)
        begin
            cnt_ra = col_rd_reg;
        end
        else
        begin
            cnt_ra = sweep_reg[bwti_pkg::SYM_W-1:0];
        end

        cnt_we = cmd.cnt_load_wr || (cmd.sum_step && pend_reg) || cmd.fill_wr;
        priority if (cmd.sum_step)
        begin
            cnt_wa = pend_addr_reg;
            cnt_wd = sum_reg;
        end
        else if (cmd.fill_wr)
        begin
            cnt_wa = col_rd_reg;
            cnt_wd = cnt_rd_reg + LW'(1);
        end
        else
        begin
            cnt_wa = byte_reg;
            cnt_wd = cnt_rd_reg + LW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_wa] <= byte_reg;
        end
        if (col_re)
        begin
            col_rd_reg <= col_mem[col_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= fill_reg[RW-1:0];
        end
        if (row_re)
        begin
            row_rd_reg <= row_mem[row_ra];
        end
    end

    // entries without a valid bit read as zero
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= vld_reg[cnt_ra] ? cnt_mem[cnt_ra] : '0;
        end
    end

    always_comb
    begin
        bl_next        = bl_reg;
        walk_next      = walk_reg;
        rem_next       = rem_reg;
        ready_next     = ready_reg;
        vld_next       = vld_reg;
        sweep_next     = sweep_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;

        if (cnt_we)
        begin
            vld_next[cnt_wa] = 1'b1;
        end
        if (cmd.bl_inc)
        begin
            bl_next = bl_reg + LW'(1);
        end
        if (cmd.sum_start)
        begin
            sweep_next = '0;
            pend_next  = 1'b0;
            sum_next   = '0;
            fill_next  = '0;
        end
        // prefix sum sweep, each write follows its read in the next cycle
        if (cmd.sum_step)
        begin
            pend_next      = sweep_rd;
            pend_addr_next = sweep_reg[bwti_pkg::SYM_W-1:0];
            if (sweep_rd)
            begin
                sweep_next = sweep_reg + bwti_pkg::SWEEP_W'(1);
            end
            if (pend_reg)
            begin
                sum_next = sum_reg + cnt_rd_reg;
            end
        end
        if (cmd.fill_wr)
        begin
            fill_next = fill_inc;
        end
        if (cmd.walk_step)
        begin
            walk_next = row_rd_reg;
            rem_next  = rem_reg - LW'(1);
        end
        if (cmd.commit)
        begin
            walk_next  = RW'(prow_reg);
            rem_next   = bl_reg;
            ready_next = 1'b1;
            vld_next   = '0;
        end
        if (cmd.discard)
        begin
            bl_next    = '0;
            walk_next  = '0;
            rem_next   = '0;
            ready_next = 1'b0;
            vld_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_reg        <= '0;
            walk_reg      <= '0;
            rem_reg       <= '0;
            ready_reg     <= 1'b0;
            vld_reg       <= '0;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            sum_reg       <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            bl_reg        <= bl_next;
            walk_reg      <= walk_next;
            rem_reg       <= rem_next;
            ready_reg     <= ready_next;
            vld_reg       <= vld_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            if (cmd.out_status == bwti_pkg::RES_OK)
            begin
                out_byte_reg  <= col_rd_reg;
                out_final_reg <= (rem_reg == '0);
            end
            else
            begin
                out_byte_reg  <= '0;
                out_final_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.is_read   = op_reg;
        stat.last      = last_reg;
        stat.ready     = ready_reg;
        stat.full      = (bl_reg == LW'(BLOCK_SIZE));
        stat.rem_zero  = (rem_reg == '0);
        stat.prow_bad  = (CW'(prow_reg) >= CW'(bl_reg));
        stat.sum_done  = sweep_reg[bwti_pkg::SWEEP_W-1] && !pend_reg;
        stat.fill_last = (fill_inc == bl_reg);
    end

    assign m_tdata = out_byte_reg;
    assign m_tlast = out_final_reg;
    assign m_tuser = out_status_reg;

endmodule

// File: src/bwt_inverse_transform.sv
// ----------------------------------------------------------------------------
// bwt_inverse_transform
// Inverse block-sorting transform of one block. Load words (tuser 0) bring
// the last-column bytes in order; the word with tlast also brings the primary
// row. Read words (tuser 1) return the original text a byte per word, tlast
// on the final byte. A word is taken only once the last one is through; a
// load waits for the read-modify-write of the histogram memory (and for the
// drop of a decoded block when it opens a new block). The last load then
// builds the next-row table: a check of the primary row, a prefix sweep over
// the 256 bins, and the fill, one block byte after another, before the next
// word is taken. A read chains the reads of the next-row table and the column
// store and the load of the output word (only the load when nothing is
// pending), plus any wait for the output word to drain.
// ----------------------------------------------------------------------------
module bwt_inverse_transform
#(
    parameter int BLOCK_SIZE = 4096
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bwti_pkg::IN_DATA_W-1:0]     s_tdata,   // in_byte, primary_row
    input  logic                               s_tuser,   // opcode
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bwti_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_byte
    output logic [bwti_pkg::STATUS_W-1:0]      m_tuser,   // status
    output logic                               m_tlast
);

    bwti_pkg::cmd_t  cmd;
    bwti_pkg::stat_t stat;

    bwti_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bwti_datapath
    #(
        .BLOCK_SIZE (BLOCK_SIZE)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !m_tvalid || m_tready)
        else $error("output word overwritten before it was taken");

    a_final_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == bwti_pkg::RES_OK)
        else $error("final flag on a status word");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != bwti_pkg::RES_OK |-> m_tdata == '0)
        else $error("data on a status word");

endmodule
